### rtl/vtms_pkg.sv
package vtms_pkg;

  localparam int TIMEOUT_W = 26;
  localparam logic [9:0] US_PER_MS = 10'd1000;
  localparam logic [47:0] REQUEST_INTERVAL_US = 48'd1000000;

  localparam logic [1:0] REG_LOCK_FRAMES   = 2'd0;
  localparam logic [1:0] REG_RELOCK_FRAMES = 2'd1;
  localparam logic [1:0] REG_SEARCH_TO     = 2'd2;
  localparam logic [1:0] REG_LOST_TO       = 2'd3;

  localparam logic [2:0] CODE_IDLE      = 3'd0;
  localparam logic [2:0] CODE_SEARCH    = 3'd1;
  localparam logic [2:0] CODE_FOLLOW    = 3'd2;
  localparam logic [2:0] CODE_INTERCEPT = 3'd3;
  localparam logic [2:0] CODE_LOST      = 3'd4;
  localparam logic [2:0] CODE_ABORT     = 3'd5;

  localparam logic [2:0] R_NONE     = 3'd0;
  localparam logic [2:0] R_PRECOND  = 3'd1;
  localparam logic [2:0] R_MANUAL   = 3'd2;
  localparam logic [2:0] R_TIMEOUT  = 3'd3;
  localparam logic [2:0] R_STALE    = 3'd4;
  localparam logic [2:0] R_TRACKING = 3'd5;

  localparam logic [1:0] SP_NONE      = 2'd0;
  localparam logic [1:0] SP_HOLD      = 2'd1;
  localparam logic [1:0] SP_FOLLOW    = 2'd2;
  localparam logic [1:0] SP_INTERCEPT = 2'd3;

  typedef enum logic [5:0] {
    M_IDLE      = 6'b000001,
    M_SEARCH    = 6'b000010,
    M_FOLLOW    = 6'b000100,
    M_INTERCEPT = 6'b001000,
    M_LOST      = 6'b010000,
    M_ABORT     = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [47:0] now_us;
    logic        activation_switch;
    logic        intercept_switch;
    logic        vehicle_ready;
    logic        stick_takeover;
    logic        tracker_lock;
    logic        sample_fresh;
    logic        have_observations;
    logic        intercept_geometry_ok;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] loss_reason;
    logic       requested_intercept;
    logic       guidance_active;
    logic       send_auto_lock;
    logic       send_stop_track;
    logic       offboard_request;
    logic [1:0] setpoint_kind;
    logic       clear_estimate;
    logic       capture_hold;
  } out_item_t;

  typedef struct packed {
    logic [7:0]           lock_frames;
    logic [7:0]           relock_frames;
    logic [TIMEOUT_W-1:0] search_us;
    logic [TIMEOUT_W-1:0] lost_us;
  } cfg_t;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    unique case (m)
      M_IDLE:      c = CODE_IDLE;
      M_SEARCH:    c = CODE_SEARCH;
      M_FOLLOW:    c = CODE_FOLLOW;
      M_INTERCEPT: c = CODE_INTERCEPT;
      M_LOST:      c = CODE_LOST;
      M_ABORT:     c = CODE_ABORT;
      default:     c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

### rtl/vtms_in_if.sv
interface vtms_in_if import vtms_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/vtms_out_if.sv
interface vtms_out_if import vtms_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/vtms_cfg.sv
module vtms_cfg import vtms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [7:0]           lock_frames;
  logic [7:0]           relock_frames;
  logic [15:0]          search_ms;
  logic [15:0]          lost_ms;
  logic [TIMEOUT_W-1:0] search_us;
  logic [TIMEOUT_W-1:0] lost_us;
  logic [TIMEOUT_W-1:0] wdata_us;
  logic                 wr;

  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite;
  assign wdata_us = TIMEOUT_W'(pwdata[15:0]) * TIMEOUT_W'(US_PER_MS);

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_frames   <= 8'd5;
      relock_frames <= 8'd3;
      search_ms     <= 16'd3000;
      lost_ms       <= 16'd2000;
      search_us     <= TIMEOUT_W'(3000) * TIMEOUT_W'(US_PER_MS);
      lost_us       <= TIMEOUT_W'(2000) * TIMEOUT_W'(US_PER_MS);
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_LOCK_FRAMES:   lock_frames <= pwdata[7:0];
        REG_RELOCK_FRAMES: relock_frames <= pwdata[7:0];
        REG_SEARCH_TO: begin
          search_ms <= pwdata[15:0];
          search_us <= wdata_us;
        end
        REG_LOST_TO: begin
          lost_ms <= pwdata[15:0];
          lost_us <= wdata_us;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LOCK_FRAMES:   prdata = {24'd0, lock_frames};
      REG_RELOCK_FRAMES: prdata = {24'd0, relock_frames};
      REG_SEARCH_TO:     prdata = {16'd0, search_ms};
      REG_LOST_TO:       prdata = {16'd0, lost_ms};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg = '{lock_frames:   lock_frames,
                 relock_frames: relock_frames,
                 search_us:     search_us,
                 lost_us:       lost_us};

endmodule

### rtl/visual_track_mode_sequencer.sv
// channel  modport  payload
// tick     sink     in_item_t   (one control tick)
// result   source   out_item_t  (one result per tick)
// apb      slave    4 registers at byte offsets 0, 4, 8, 12
//
// One request per cycle sustained while the result channel is ready. A tick is registered
// on acceptance, evaluated against the sequencer state and written to the result register
// once that register is free. State and the result register update together.
// A stalled result holds its register; one more tick waits in the input register.
// rst is synchronous and restores the register defaults and idle mode.
module visual_track_mode_sequencer import vtms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  vtms_in_if.sink     tick,
  vtms_out_if.source  result
);

  cfg_t cfg;

  vtms_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic      a_valid;
  in_item_t  a_data;
  logic      o_valid;
  out_item_t o_data;
  logic      o_free;
  logic      fire;

  mode_t       cur_mode, cur_mode_next;
  logic [2:0]  cur_reason, cur_reason_next;
  logic        prev_activation;
  logic [7:0]  lock_streak, lock_streak_next;
  logic [7:0]  relock_streak, relock_streak_next;
  logic [47:0] mode_enter_time, mode_enter_time_next;
  logic [47:0] last_request_time, last_request_time_next;
  out_item_t   res;

  assign o_free       = !o_valid || result.ready;
  assign fire         = a_valid && o_free;
  assign tick.ready   = !a_valid || o_free;
  assign result.valid = o_valid;
  assign result.data  = o_data;

  always_comb begin
    logic [47:0] now;
    logic        obs, usable, allowed, p_lock, p_stop, p_clear, p_capture, req;
    logic [7:0]  inc;
    logic [1:0]  kind;
    now       = a_data.now_us;
    obs       = a_data.have_observations;
    p_lock    = 1'b0;
    p_stop    = 1'b0;
    p_clear   = 1'b0;
    p_capture = 1'b0;
    req       = 1'b0;
    inc       = 8'd0;
    kind      = SP_NONE;
    cur_mode_next          = cur_mode;
    cur_reason_next        = cur_reason;
    lock_streak_next       = lock_streak;
    relock_streak_next     = relock_streak;
    mode_enter_time_next   = mode_enter_time;
    last_request_time_next = last_request_time;

    if (a_data.activation_switch && !prev_activation && a_data.vehicle_ready) begin
      obs       = 1'b0;
      p_clear   = 1'b1;
      p_capture = 1'b1;
      p_lock    = 1'b1;
      cur_mode_next        = M_SEARCH;
      cur_reason_next      = R_NONE;
      mode_enter_time_next = now;
      lock_streak_next     = 8'd0;
      relock_streak_next   = 8'd0;
    end
    if (!a_data.activation_switch && prev_activation && cur_mode_next != M_IDLE) begin
      p_stop               = 1'b1;
      cur_mode_next        = M_ABORT;
      cur_reason_next      = R_PRECOND;
      mode_enter_time_next = now;
    end
    if (cur_mode_next != M_IDLE && cur_mode_next != M_ABORT) begin
      if (!a_data.vehicle_ready) begin
        p_stop               = 1'b1;
        cur_mode_next        = M_ABORT;
        cur_reason_next      = R_PRECOND;
        mode_enter_time_next = now;
      end else if (a_data.stick_takeover) begin
        p_stop               = 1'b1;
        cur_mode_next        = M_ABORT;
        cur_reason_next      = R_MANUAL;
        mode_enter_time_next = now;
      end
    end

    usable  = a_data.tracker_lock && a_data.sample_fresh && obs;
    allowed = usable && a_data.intercept_geometry_ok;

    unique case (cur_mode_next) inside
      M_SEARCH: begin
        if (usable) begin
          inc = (lock_streak_next == 8'hFF) ? 8'hFF : lock_streak_next + 8'd1;
          lock_streak_next = inc;
          if (inc >= cfg.lock_frames) begin
            cur_mode_next        = M_FOLLOW;
            cur_reason_next      = R_NONE;
            mode_enter_time_next = now;
          end
        end else begin
          lock_streak_next = 8'd0;
          if ((now - mode_enter_time_next) > {22'd0, cfg.search_us}) begin
            cur_mode_next        = M_LOST;
            cur_reason_next      = R_TIMEOUT;
            mode_enter_time_next = now;
            relock_streak_next   = 8'd0;
            p_capture            = 1'b1;
          end
        end
      end
      M_FOLLOW, M_INTERCEPT: begin
        if (!usable) begin
          cur_mode_next        = M_LOST;
          cur_reason_next      = a_data.tracker_lock ? R_STALE : R_TRACKING;
          mode_enter_time_next = now;
          relock_streak_next   = 8'd0;
          p_capture            = 1'b1;
        end else if ((cur_mode_next == M_FOLLOW) &&
                     a_data.intercept_switch && allowed) begin
          cur_mode_next        = M_INTERCEPT;
          cur_reason_next      = R_NONE;
          mode_enter_time_next = now;
        end else if ((cur_mode_next == M_INTERCEPT) &&
                     (!a_data.intercept_switch || !allowed)) begin
          cur_mode_next        = M_FOLLOW;
          cur_reason_next      = R_NONE;
          mode_enter_time_next = now;
        end
      end
      M_LOST: begin
        if (usable) begin
          inc = (relock_streak_next == 8'hFF) ? 8'hFF : relock_streak_next + 8'd1;
          relock_streak_next = inc;
          if (inc >= cfg.relock_frames) begin
            cur_mode_next        = (a_data.intercept_switch && allowed) ? M_INTERCEPT
                                                                        : M_FOLLOW;
            cur_reason_next      = R_NONE;
            mode_enter_time_next = now;
          end
        end else begin
          relock_streak_next = 8'd0;
          if ((now - mode_enter_time_next) > {22'd0, cfg.lost_us}) begin
            p_stop               = 1'b1;
            cur_mode_next        = M_ABORT;
            mode_enter_time_next = now;
          end
        end
      end
      M_ABORT: begin
        cur_mode_next        = M_IDLE;
        cur_reason_next      = R_NONE;
        mode_enter_time_next = now;
        p_clear              = 1'b1;
      end
      default: ;
    endcase

    case (cur_mode_next) inside
      M_SEARCH, M_LOST: kind = SP_HOLD;
      M_FOLLOW:         kind = SP_FOLLOW;
      M_INTERCEPT:      kind = SP_INTERCEPT;
      default:          kind = SP_NONE;
    endcase

    if (kind != SP_NONE && (now - last_request_time) >= REQUEST_INTERVAL_US) begin
      req                    = 1'b1;
      last_request_time_next = now;
    end

    res.mode                = mode_code(cur_mode_next);
    res.loss_reason         = cur_reason_next;
    res.requested_intercept = a_data.intercept_switch;
    res.guidance_active     = (cur_mode_next != M_IDLE) && (cur_mode_next != M_ABORT);
    res.send_auto_lock      = p_lock;
    res.send_stop_track     = p_stop;
    res.offboard_request    = req;
    res.setpoint_kind       = kind;
    res.clear_estimate      = p_clear;
    res.capture_hold        = p_capture;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid           <= 1'b0;
      o_valid           <= 1'b0;
      cur_mode          <= M_IDLE;
      cur_reason        <= R_NONE;
      prev_activation   <= 1'b0;
      lock_streak       <= 8'd0;
      relock_streak     <= 8'd0;
      mode_enter_time   <= 48'd0;
      last_request_time <= 48'd0;
    end else begin
      if (tick.valid && tick.ready) begin
        a_valid <= 1'b1;
      end else if (fire) begin
        a_valid <= 1'b0;
      end
      if (fire) begin
        o_valid           <= 1'b1;
        cur_mode          <= cur_mode_next;
        cur_reason        <= cur_reason_next;
        prev_activation   <= a_data.activation_switch;
        lock_streak       <= lock_streak_next;
        relock_streak     <= relock_streak_next;
        mode_enter_time   <= mode_enter_time_next;
        last_request_time <= last_request_time_next;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      a_data <= tick.data;
    end
    if (fire) begin
      o_data <= res;
    end
  end

endmodule

### dv/visual_track_mode_sequencer_tb.sv
`timescale 1ns / 1ps

module visual_track_mode_sequencer_tb;
  import vtms_pkg::*;

  typedef struct {
    in_item_t  tick;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  vtms_in_if  tick_ch ();
  vtms_out_if result_ch ();

  visual_track_mode_sequencer u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tick    (tick_ch),
    .result  (result_ch)
  );

  always #5 clk = ~clk;

  // sequencer prediction state
  logic [2:0]  sq_mode;
  logic [2:0]  sq_reason;
  bit          sq_prev_act;
  logic [7:0]  lock_run;
  logic [7:0]  relock_run;
  logic [47:0] entered_at;
  logic [47:0] last_req_at;
  logic [7:0]  cfg_lock;
  logic [7:0]  cfg_relock;
  logic [15:0] cfg_search_ms;
  logic [15:0] cfg_lost_ms;
  bit          pl_lock, pl_stop, pl_clear, pl_capture;

  out_item_t   mode_results_q[$];
  dir_row_t    directed[$];
  out_item_t   got, want;
  int          errors = 0;
  int          ticks_sent = 0;
  int          results_seen = 0;
  int          offboard_seen = 0;
  int          mode_hits[8];
  int          settings_used = 1;
  bit          calm = 1'b0;
  logic [47:0] now_t;
  bit          act_lvl, icpt_lvl;

  function automatic void enter_mode(input logic [2:0] m, input logic [2:0] why,
                                     input logic [47:0] now);
    sq_mode    = m;
    sq_reason  = why;
    entered_at = now;
    if (m == CODE_SEARCH) begin
      lock_run   = '0;
      relock_run = '0;
    end else if (m == CODE_LOST) begin
      relock_run = '0;
      pl_capture = 1'b1;
    end else if (m == CODE_IDLE) begin
      pl_clear = 1'b1;
    end
  endfunction

  function automatic void abort_to(input logic [2:0] why, input logic [47:0] now);
    pl_stop = 1'b1;
    enter_mode(CODE_ABORT, why, now);
  endfunction

  function automatic bit elapsed_over(input logic [47:0] now, input logic [15:0] ms);
    logic [47:0] d;
    d = now - entered_at;
    return {16'd0, d} > 64'(ms) * 64'(US_PER_MS);
  endfunction

  function automatic out_item_t step_sequencer(input in_item_t t);
    out_item_t  o;
    bit         obs, usable, allowed, req;
    logic [1:0] kind;
    obs = t.have_observations;
    req = 1'b0;
    kind = SP_NONE;
    pl_lock = 1'b0;
    pl_stop = 1'b0;
    pl_clear = 1'b0;
    pl_capture = 1'b0;

    if (t.activation_switch && !sq_prev_act && t.vehicle_ready) begin
      obs = 1'b0;
      pl_clear = 1'b1;
      pl_capture = 1'b1;
      pl_lock = 1'b1;
      enter_mode(CODE_SEARCH, R_NONE, t.now_us);
    end
    if (!t.activation_switch && sq_prev_act && sq_mode != CODE_IDLE)
      abort_to(R_PRECOND, t.now_us);
    sq_prev_act = t.activation_switch;

    if (sq_mode != CODE_IDLE && sq_mode != CODE_ABORT) begin
      if (!t.vehicle_ready)
        abort_to(R_PRECOND, t.now_us);
      else if (t.stick_takeover)
        abort_to(R_MANUAL, t.now_us);
    end

    usable  = t.tracker_lock && t.sample_fresh && obs;
    allowed = usable && t.intercept_geometry_ok;

    case (sq_mode)
      CODE_SEARCH: begin
        if (usable) begin
          if (lock_run != 8'hFF) lock_run = lock_run + 8'd1;
          if (lock_run >= cfg_lock) enter_mode(CODE_FOLLOW, R_NONE, t.now_us);
        end else begin
          lock_run = '0;
          if (elapsed_over(t.now_us, cfg_search_ms))
            enter_mode(CODE_LOST, R_TIMEOUT, t.now_us);
        end
      end
      CODE_FOLLOW: begin
        if (!usable)
          enter_mode(CODE_LOST, t.tracker_lock ? R_STALE : R_TRACKING, t.now_us);
        else if (t.intercept_switch && allowed)
          enter_mode(CODE_INTERCEPT, R_NONE, t.now_us);
      end
      CODE_INTERCEPT: begin
        if (!usable)
          enter_mode(CODE_LOST, t.tracker_lock ? R_STALE : R_TRACKING, t.now_us);
        else if (!t.intercept_switch || !allowed)
          enter_mode(CODE_FOLLOW, R_NONE, t.now_us);
      end
      CODE_LOST: begin
        if (usable) begin
          if (relock_run != 8'hFF) relock_run = relock_run + 8'd1;
          if (relock_run >= cfg_relock)
            enter_mode((t.intercept_switch && allowed) ? CODE_INTERCEPT : CODE_FOLLOW,
                       R_NONE, t.now_us);
        end else begin
          relock_run = '0;
          if (elapsed_over(t.now_us, cfg_lost_ms)) abort_to(sq_reason, t.now_us);
        end
      end
      CODE_ABORT: enter_mode(CODE_IDLE, R_NONE, t.now_us);
      default: ;
    endcase

    if (sq_mode == CODE_SEARCH || sq_mode == CODE_LOST) kind = SP_HOLD;
    else if (sq_mode == CODE_FOLLOW) kind = SP_FOLLOW;
    else if (sq_mode == CODE_INTERCEPT) kind = SP_INTERCEPT;

    if (kind != SP_NONE && (t.now_us - last_req_at) >= REQUEST_INTERVAL_US) begin
      req = 1'b1;
      last_req_at = t.now_us;
    end

    o.mode                = sq_mode;
    o.loss_reason         = sq_reason;
    o.requested_intercept = t.intercept_switch;
    o.guidance_active     = (sq_mode != CODE_IDLE && sq_mode != CODE_ABORT);
    o.send_auto_lock      = pl_lock;
    o.send_stop_track     = pl_stop;
    o.offboard_request    = req;
    o.setpoint_kind       = kind;
    o.clear_estimate      = pl_clear;
    o.capture_hold        = pl_capture;
    return o;
  endfunction

  function automatic in_item_t mk(input logic [47:0] now, input bit act, input bit icpt,
                                  input bit rdy, input bit tko, input bit lck, input bit frs,
                                  input bit obs, input bit geo);
    in_item_t t;
    t.now_us = now;
    t.activation_switch = act;
    t.intercept_switch = icpt;
    t.vehicle_ready = rdy;
    t.stick_takeover = tko;
    t.tracker_lock = lck;
    t.sample_fresh = frs;
    t.have_observations = obs;
    t.intercept_geometry_ok = geo;
    return t;
  endfunction

  function automatic out_item_t idle_out(input bit icpt, input bit stop, input bit clr);
    out_item_t o;
    o = '0;
    o.mode = CODE_IDLE;
    o.loss_reason = R_NONE;
    o.setpoint_kind = SP_NONE;
    o.requested_intercept = icpt;
    o.send_stop_track = stop;
    o.clear_estimate = clr;
    return o;
  endfunction

  task automatic report_field(input string f, input logic [47:0] e, input logic [47:0] a);
    errors++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, f, e, a);
  endtask

  task automatic put_tick(input in_item_t t, input bit typed, input out_item_t fixed);
    out_item_t p;
    while (!calm && $urandom_range(0, 99) < 30) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.data  <= t;
    do @(posedge clk); while (tick_ch.ready !== 1'b1);
    p = step_sequencer(t);
    mode_results_q.push_back(typed ? fixed : p);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    while (mode_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [31:0] exp_val);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== exp_val)
      report_field($sformatf("register %0d readback", idx), 48'(exp_val), 48'(rd));
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
    logic [31:0] rd, m, v;
    m = (idx == REG_LOCK_FRAMES || idx == REG_RELOCK_FRAMES) ? 32'hFF : 32'hFFFF;
    v = {16'd0, val} & m;
    apb_xfer(1'b1, idx, ($urandom & ~m) | v, rd);
    case (idx)
      REG_LOCK_FRAMES:   cfg_lock = v[7:0];
      REG_RELOCK_FRAMES: cfg_relock = v[7:0];
      REG_SEARCH_TO:     cfg_search_ms = v[15:0];
      REG_LOST_TO:       cfg_lost_ms = v[15:0];
      default: ;
    endcase
    check_reg(idx, v);
  endtask

  task automatic run_phase(input int n, input int quality);
    in_item_t t;
    int       r;
    logic [63:0] jump;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 && quality < 80) drain_results();
      r = $urandom_range(0, 99);
      if (r < 85) begin
        now_t = now_t + 48'd20000;
      end else if (r < 95) begin
        now_t = now_t + 48'($urandom_range(0, 500000));
      end else begin
        jump = {$urandom, $urandom};
        now_t = jump[47:0];
      end
      if ($urandom_range(0, 99) < ((sq_mode == CODE_IDLE) ? 25 : 3)) act_lvl = !act_lvl;
      if ($urandom_range(0, 99) < 10) icpt_lvl = !icpt_lvl;
      t = mk(now_t, act_lvl, icpt_lvl, $urandom_range(0, 99) < 96,
             $urandom_range(0, 99) < 3, 1'b1, 1'b1, 1'b1, $urandom_range(0, 99) < 85);
      if ($urandom_range(0, 99) >= quality) begin
        t.tracker_lock = 1'($urandom);
        t.sample_fresh = 1'($urandom);
        t.have_observations = 1'($urandom);
      end
      put_tick(t, 1'b0, '0);
    end
    drain_results();
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    result_ch.ready <= calm || ($urandom_range(0, 99) >= 30);
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      got = result_ch.data;
      if (mode_results_q.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, got %0h", $time, got);
      end else begin
        want = mode_results_q.pop_front();
        results_seen++;
        if (got.mode !== want.mode) report_field("mode", 48'(want.mode), 48'(got.mode));
        if (got.loss_reason !== want.loss_reason)
          report_field("loss_reason", 48'(want.loss_reason), 48'(got.loss_reason));
        if (got.requested_intercept !== want.requested_intercept)
          report_field("requested_intercept", 48'(want.requested_intercept),
                       48'(got.requested_intercept));
        if (got.guidance_active !== want.guidance_active)
          report_field("guidance_active", 48'(want.guidance_active),
                       48'(got.guidance_active));
        if (got.send_auto_lock !== want.send_auto_lock)
          report_field("send_auto_lock", 48'(want.send_auto_lock),
                       48'(got.send_auto_lock));
        if (got.send_stop_track !== want.send_stop_track)
          report_field("send_stop_track", 48'(want.send_stop_track),
                       48'(got.send_stop_track));
        if (got.offboard_request !== want.offboard_request)
          report_field("offboard_request", 48'(want.offboard_request),
                       48'(got.offboard_request));
        if (got.setpoint_kind !== want.setpoint_kind)
          report_field("setpoint_kind", 48'(want.setpoint_kind), 48'(got.setpoint_kind));
        if (got.clear_estimate !== want.clear_estimate)
          report_field("clear_estimate", 48'(want.clear_estimate),
                       48'(got.clear_estimate));
        if (got.capture_hold !== want.capture_hold)
          report_field("capture_hold", 48'(want.capture_hold), 48'(got.capture_hold));
        mode_hits[want.mode]++;
        if (want.offboard_request) offboard_seen++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("visual_track_mode_sequencer test failed");
    $finish;
  end

  initial begin
    tick_ch.valid = 1'b0;
    tick_ch.data = '0;
    result_ch.ready = 1'b0;
    sq_mode = CODE_IDLE;
    sq_reason = R_NONE;
    sq_prev_act = 1'b0;
    lock_run = '0;
    relock_run = '0;
    entered_at = '0;
    last_req_at = '0;
    cfg_lock = 8'd5;
    cfg_relock = 8'd3;
    cfg_search_ms = 16'd3000;
    cfg_lost_ms = 16'd2000;
    act_lvl = 1'b0;
    icpt_lvl = 1'b0;
    foreach (mode_hits[i]) mode_hits[i] = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_reg(REG_LOCK_FRAMES, 32'd5);
    check_reg(REG_RELOCK_FRAMES, 32'd3);
    check_reg(REG_SEARCH_TO, 32'd3000);
    check_reg(REG_LOST_TO, 32'd2000);

    // directed: default registers
    directed.push_back('{mk(48'd0, 0, 0, 0, 0, 0, 0, 0, 0), 1, idle_out(0, 0, 0)});
    directed.push_back('{mk(48'd20000, 1, 1, 0, 0, 1, 1, 1, 1), 1, idle_out(1, 0, 0)});
    directed.push_back('{mk(48'd40000, 0, 0, 1, 0, 0, 0, 0, 0), 1, idle_out(0, 0, 0)});
    // activation tick ignores observations
    directed.push_back('{mk(48'd60000, 1, 0, 1, 0, 1, 1, 1, 1), 0, '0});
    for (int k = 0; k < 5; k++)
      directed.push_back('{mk(48'd1000000 + 48'(k * 20000), 1, 0, 1, 0, 1, 1, 1, 1), 0, '0});
    directed.push_back('{mk(48'd1100000, 1, 1, 1, 0, 1, 1, 1, 1), 0, '0});
    directed.push_back('{mk(48'd1140000, 1, 0, 1, 0, 1, 0, 1, 1), 0, '0});
    directed.push_back('{mk(48'd3200000, 1, 0, 1, 0, 0, 1, 1, 1), 0, '0});
    directed.push_back('{mk(48'd3220000, 1, 0, 1, 0, 0, 1, 1, 1), 0, '0});
    directed.push_back('{mk(48'd3240000, 0, 0, 1, 0, 0, 0, 0, 0), 0, '0});
    // activation and takeover together: all pulses at once
    directed.push_back('{mk(48'd3260000, 1, 0, 1, 1, 0, 0, 0, 0), 0, '0});
    directed.push_back('{mk(48'd3280000, 0, 0, 1, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{mk(48'd3300000, 1, 0, 1, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{mk(48'd3320000, 1, 0, 1, 1, 0, 0, 0, 0), 1, idle_out(0, 1, 1)});
    directed.push_back('{mk(48'd3340000, 0, 0, 1, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{mk(48'd3360000, 1, 0, 1, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{mk(48'd3380000, 1, 1, 0, 0, 0, 0, 0, 0), 1, idle_out(1, 1, 1)});
    directed.push_back('{mk(48'd3400000, 0, 0, 1, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{mk(48'd3420000, 1, 0, 1, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{mk(48'd3440000, 0, 0, 1, 0, 0, 0, 0, 0), 1, idle_out(0, 1, 1)});
    // search timeout, then lost timeout, then the return to idle across the time wrap
    directed.push_back('{mk(48'd5000000, 1, 0, 1, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{mk(48'd8000001, 1, 0, 1, 0, 1, 0, 1, 0), 0, '0});
    directed.push_back('{mk(48'hFFFF_FFFF_FFF0, 1, 1, 1, 0, 0, 1, 1, 1), 0, '0});
    directed.push_back('{mk(48'h0000_0000_0010, 1, 1, 1, 0, 1, 1, 1, 1), 0, '0});
    foreach (directed[i]) put_tick(directed[i].tick, directed[i].typed, directed[i].want);
    drain_results();
    act_lvl = sq_prev_act;
    now_t = 48'h0000_0000_0010;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          set_reg(REG_LOCK_FRAMES, 16'd0);
          set_reg(REG_RELOCK_FRAMES, 16'd0);
          set_reg(REG_SEARCH_TO, 16'd0);
          set_reg(REG_LOST_TO, 16'd0);
        end
        1: begin
          set_reg(REG_LOCK_FRAMES, 16'd255);
          set_reg(REG_RELOCK_FRAMES, 16'd255);
          set_reg(REG_SEARCH_TO, 16'hFFFF);
          set_reg(REG_LOST_TO, 16'hFFFF);
        end
        3: begin
          set_reg(REG_LOCK_FRAMES, 16'd1);
          set_reg(REG_RELOCK_FRAMES, 16'd0);
          set_reg(REG_SEARCH_TO, 16'd1);
          set_reg(REG_LOST_TO, 16'hFFFF);
        end
        default: begin
          set_reg(REG_LOCK_FRAMES, 16'($urandom_range(0, 8)));
          set_reg(REG_RELOCK_FRAMES, 16'($urandom_range(0, 5)));
          set_reg(REG_SEARCH_TO, 16'($urandom_range(0, 400)));
          set_reg(REG_LOST_TO, 16'($urandom_range(0, 400)));
        end
      endcase
      settings_used++;
      calm = (ph == 2);
      run_phase(88, (ph == 1) ? 95 : 75);
    end
    calm = 1'b0;

    drain_results();
    repeat (10) @(posedge clk);

    $display("Sent %0d ticks over %0d register settings, %0d results checked.",
             ticks_sent, settings_used, results_seen);
    $display("Results by mode: search %0d follow %0d intercept %0d lost %0d, offboard %0d.",
             mode_hits[CODE_SEARCH], mode_hits[CODE_FOLLOW], mode_hits[CODE_INTERCEPT],
             mode_hits[CODE_LOST], offboard_seen);
    if (errors == 0) begin
      $display("visual_track_mode_sequencer test passed");
    end else begin
      $display("visual_track_mode_sequencer test failed");
    end
    $finish;
  end

endmodule

### visual_track_mode_sequencer.f
rtl/vtms_pkg.sv
rtl/vtms_in_if.sv
rtl/vtms_out_if.sv
rtl/vtms_cfg.sv
rtl/visual_track_mode_sequencer.sv
dv/visual_track_mode_sequencer_tb.sv
